/* design/hpm_pkg.sv */
// Shared widths, register indexes and reset values of the homography point mapper.
package hpm_pkg;

    // Field widths fixed by the interface.
    localparam int COEF_W  = 32;
    localparam int PT_W    = 16;
    localparam int OUT_W   = 32;
    localparam int PROD_W  = COEF_W + PT_W;
    // Homogeneous sums stay below 2^48 in magnitude for every coefficient pattern.
    localparam int ACC_W   = PROD_W + 2;
    localparam int NUM_REGS = 8;
    localparam int CFG_IDX_W = 3;

    // Default fixed-point formats.
    localparam int COEF_FRAC_BITS_DEF  = 16;
    localparam int COORD_FRAC_BITS_DEF = 4;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_M_XX = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_M_XY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_M_XT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_M_YX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_M_YY = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_M_YT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_M_WX = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_M_WY = 3'd7;

    // Reset values: identity transform.
    localparam logic signed [COEF_W-1:0] COEF_ONE  = 32'sd65536;
    localparam logic signed [COEF_W-1:0] COEF_ZERO = 32'sd0;

    // Per-item flags that travel alongside the division pipeline.
    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic ovf_x;
        logic ovf_y;
        logic clamped;
    } hpm_flags_t;

endpackage

/* design/homography_point_mapper.sv */
// Top level of the homography point mapper: coefficient registers and pipeline.
//
//  Channel   Direction  Transaction contents
//  s_axis    in         tdata: point_x [15:0], point_y [31:16]
//  m_axis    out        tdata: map_x [31:0], map_y [63:32]; tuser: w_clamped, saturated
//  cfg       in         one coefficient register write per cycle with cfg_we high
//
// One point enters per cycle while the output does not wait. Each point passes three
// set-up stages, one divider stage per quotient bit and the output register.
// The whole pipeline holds while the output waits.
// Reset loads the identity transform and empties the pipeline.
module homography_point_mapper #(
    parameter int COEF_FRAC_BITS  = hpm_pkg::COEF_FRAC_BITS_DEF,
    parameter int COORD_FRAC_BITS = hpm_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [31:0]                      s_axis_tdata,  // point_x, point_y
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [63:0]                      m_axis_tdata,  // map_x, map_y
    output logic [1:0]                       m_axis_tuser,  // w_clamped, saturated
    input  logic                             cfg_we,
    input  logic [hpm_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [hpm_pkg::COEF_W-1:0]       cfg_data
);
    import hpm_pkg::*;

    localparam int QB    = OUT_W + COEF_FRAC_BITS + 1;
    localparam int DEPTH = 3 + QB;

    logic signed [COEF_W-1:0] coef_reg [NUM_REGS];
    logic                     en;
    logic [DEPTH-1:0]         valid_reg;
    logic                     out_valid_reg;
    logic [OUT_W-1:0]         map_x_reg, map_y_reg;
    logic                     clamp_reg, sat_reg;

    logic [ACC_W-1:0] r_x [QB+1];
    logic [ACC_W-1:0] r_y [QB+1];
    logic [31:0]      n_x [QB+1];
    logic [31:0]      n_y [QB+1];
    logic [QB-1:0]    q_x [QB+1];
    logic [QB-1:0]    q_y [QB+1];
    logic [ACC_W-1:0] d_p [QB+1];
    hpm_flags_t       f_p [QB+1];

    logic [OUT_W-1:0] val_x, val_y;
    logic             sat_x, sat_y;

    // Coefficient registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg[REG_M_XX] <= COEF_ONE;
            coef_reg[REG_M_XY] <= COEF_ZERO;
            coef_reg[REG_M_XT] <= COEF_ZERO;
            coef_reg[REG_M_YX] <= COEF_ZERO;
            coef_reg[REG_M_YY] <= COEF_ONE;
            coef_reg[REG_M_YT] <= COEF_ZERO;
            coef_reg[REG_M_WX] <= COEF_ZERO;
            coef_reg[REG_M_WY] <= COEF_ZERO;
        end
        else if (cfg_we)
        begin
            coef_reg[cfg_addr] <= cfg_data;
        end
    end

    // The pipeline advances whenever the output register is free or being drained.
    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg     <= {valid_reg[DEPTH-2:0], s_axis_tvalid};
            out_valid_reg <= valid_reg[DEPTH-1];
        end
    end

    // Products, sums and division set-up.
    hpm_front #(
        .COEF_FRAC_BITS  (COEF_FRAC_BITS),
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_front (
        .clk     (clk),
        .en      (en),
        .point_x (s_axis_tdata[15:0]),
        .point_y (s_axis_tdata[31:16]),
        .coef    (coef_reg),
        .r_x     (r_x[0]),
        .r_y     (r_y[0]),
        .num_x   (n_x[0]),
        .num_y   (n_y[0]),
        .den     (d_p[0]),
        .flags   (f_p[0])
    );

    assign q_x[0] = '0;
    assign q_y[0] = '0;

    // Divider pipeline: one quotient bit per stage for each coordinate.
    for (genvar i = 0; i < QB; i++)
    begin : g_div
        hpm_div_step #(.QB(QB)) u_step_x (
            .clk     (clk),
            .en      (en),
            .r_in    (r_x[i]),
            .num_in  (n_x[i]),
            .q_in    (q_x[i]),
            .d       (d_p[i]),
            .r_out   (r_x[i+1]),
            .num_out (n_x[i+1]),
            .q_out   (q_x[i+1])
        );

        hpm_div_step #(.QB(QB)) u_step_y (
            .clk     (clk),
            .en      (en),
            .r_in    (r_y[i]),
            .num_in  (n_y[i]),
            .q_in    (q_y[i]),
            .d       (d_p[i]),
            .r_out   (r_y[i+1]),
            .num_out (n_y[i+1]),
            .q_out   (q_y[i+1])
        );

        logic [ACC_W-1:0] d_reg;
        hpm_flags_t       f_reg;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_reg <= d_p[i];
                f_reg <= f_p[i];
            end
        end

        assign d_p[i+1] = d_reg;
        assign f_p[i+1] = f_reg;
    end

    // Rounding, saturation and sign.
    hpm_round #(.QB(QB)) u_round_x (
        .q     (q_x[QB]),
        .neg   (f_p[QB].neg_x),
        .ovf   (f_p[QB].ovf_x),
        .value (val_x),
        .sat   (sat_x)
    );

    hpm_round #(.QB(QB)) u_round_y (
        .q     (q_y[QB]),
        .neg   (f_p[QB].neg_y),
        .ovf   (f_p[QB].ovf_y),
        .value (val_y),
        .sat   (sat_y)
    );

    // Output register.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            map_x_reg <= val_x;
            map_y_reg <= val_y;
            clamp_reg <= f_p[QB].clamped;
            sat_reg   <= sat_x || sat_y;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {map_y_reg, map_x_reg};
    assign m_axis_tuser  = {sat_reg, clamp_reg};

endmodule

/* design/hpm_div_step.sv */
// One registered restoring-division step: produces one quotient bit.
module hpm_div_step #(
    parameter int QB = 49
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic [hpm_pkg::ACC_W-1:0]   r_in,
    input  logic [31:0]                 num_in,
    input  logic [QB-1:0]               q_in,
    input  logic [hpm_pkg::ACC_W-1:0]   d,
    output logic [hpm_pkg::ACC_W-1:0]   r_out,
    output logic [31:0]                 num_out,
    output logic [QB-1:0]               q_out
);
    import hpm_pkg::*;

    logic [ACC_W:0]   trial;
    logic             take;
    logic [ACC_W-1:0] r_next;
    logic [ACC_W-1:0] r_reg;
    logic [31:0]      num_reg;
    logic [QB-1:0]    q_reg;

    // Bring down the next numerator bit and try a subtraction.
    always_comb
    begin
        trial = {r_in, num_in[31]};
        take  = (trial >= {1'b0, d});
        if (take)
        begin
            r_next = ACC_W'(trial - {1'b0, d});
        end
        else
        begin
            r_next = trial[ACC_W-1:0];
        end
    end

    // Payload registers; they hold while the pipeline is stalled.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg   <= r_next;
            num_reg <= {num_in[30:0], 1'b0};
            q_reg   <= {q_in[QB-2:0], take};
        end
    end

    assign r_out   = r_reg;
    assign num_out = num_reg;
    assign q_out   = q_reg;

endmodule

/* design/hpm_round.sv */
// Rounds a quotient magnitude, saturates it and applies the sign.
module hpm_round #(
    parameter int QB = 49
) (
    input  logic [QB-1:0]               q,
    input  logic                        neg,
    input  logic                        ovf,
    output logic [hpm_pkg::OUT_W-1:0]   value,
    output logic                        sat
);
    import hpm_pkg::*;

    logic [QB:0]   q_inc;
    logic [QB-1:0] q_rnd;
    logic [QB-1:0] lim;
    logic [QB-1:0] mag;

    // The extra quotient bit gives round to nearest, ties away from zero.
    always_comb
    begin
        q_inc = {1'b0, q} + {{QB{1'b0}}, 1'b1};
        q_rnd = q_inc[QB:1];
        lim   = neg ? (QB'(1) << (OUT_W - 1)) : ((QB'(1) << (OUT_W - 1)) - QB'(1));
        sat   = ovf || (q_rnd > lim);
        mag   = sat ? lim : q_rnd;
        value = neg ? OUT_W'(~mag + QB'(1)) : mag[OUT_W-1:0];
    end

endmodule

/* design/hpm_front.sv */
// Homogeneous product, sums and division set-up, in three register stages.
module hpm_front #(
    parameter int COEF_FRAC_BITS  = hpm_pkg::COEF_FRAC_BITS_DEF,
    parameter int COORD_FRAC_BITS = hpm_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               en,
    input  logic signed [hpm_pkg::PT_W-1:0]    point_x,
    input  logic signed [hpm_pkg::PT_W-1:0]    point_y,
    input  logic signed [hpm_pkg::COEF_W-1:0]  coef [hpm_pkg::NUM_REGS],
    output logic [hpm_pkg::ACC_W-1:0]          r_x,
    output logic [hpm_pkg::ACC_W-1:0]          r_y,
    output logic [31:0]                        num_x,
    output logic [31:0]                        num_y,
    output logic [hpm_pkg::ACC_W-1:0]          den,
    output hpm_pkg::hpm_flags_t                flags
);
    import hpm_pkg::*;

    localparam logic signed [ACC_W-1:0] W_ONE = ACC_W'(1) << (COEF_FRAC_BITS + COORD_FRAC_BITS);

    logic signed [PROD_W-1:0] prod_reg [6];
    logic signed [ACC_W-1:0]  tx_reg;
    logic signed [ACC_W-1:0]  ty_reg;
    logic signed [ACC_W-1:0]  sx_next, sy_next, sw_next;
    logic signed [ACC_W-1:0]  sx_reg, sy_reg, sw_reg;
    logic signed [ACC_W-1:0]  w_use;
    logic [ACC_W-1:0]         mx, my, mw;
    hpm_flags_t               flags_next;
    logic [ACC_W-1:0]         rx_reg, ry_reg, den_reg;
    logic [31:0]              nx_reg, ny_reg;
    hpm_flags_t               flags_reg;

    // Stage one: the six coefficient products and the translation terms.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg[0] <= PROD_W'(coef[REG_M_XX] * point_x);
            prod_reg[1] <= PROD_W'(coef[REG_M_XY] * point_y);
            prod_reg[2] <= PROD_W'(coef[REG_M_YX] * point_x);
            prod_reg[3] <= PROD_W'(coef[REG_M_YY] * point_y);
            prod_reg[4] <= PROD_W'(coef[REG_M_WX] * point_x);
            prod_reg[5] <= PROD_W'(coef[REG_M_WY] * point_y);
            tx_reg      <= ACC_W'(coef[REG_M_XT]) <<< COORD_FRAC_BITS;
            ty_reg      <= ACC_W'(coef[REG_M_YT]) <<< COORD_FRAC_BITS;
        end
    end

    // Stage two: the homogeneous sums.
    always_comb
    begin
        sx_next = ACC_W'(prod_reg[0]) + ACC_W'(prod_reg[1]) + tx_reg;
        sy_next = ACC_W'(prod_reg[2]) + ACC_W'(prod_reg[3]) + ty_reg;
        sw_next = ACC_W'(prod_reg[4]) + ACC_W'(prod_reg[5]) + W_ONE;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx_reg <= sx_next;
            sy_reg <= sy_next;
            sw_reg <= sw_next;
        end
    end

    // Stage three: clamp w, take magnitudes and detect integer overflow.
    always_comb
    begin
        flags_next.clamped = (sw_reg == '0);
        w_use = flags_next.clamped ? ACC_W'(1) : sw_reg;
        mx = sx_reg[ACC_W-1] ? ACC_W'(-sx_reg) : sx_reg;
        my = sy_reg[ACC_W-1] ? ACC_W'(-sy_reg) : sy_reg;
        mw = w_use[ACC_W-1] ? ACC_W'(-w_use) : w_use;
        flags_next.neg_x = sx_reg[ACC_W-1] ^ w_use[ACC_W-1];
        flags_next.neg_y = sy_reg[ACC_W-1] ^ w_use[ACC_W-1];
        flags_next.ovf_x = (ACC_W'(mx[ACC_W-1:32]) >= mw);
        flags_next.ovf_y = (ACC_W'(my[ACC_W-1:32]) >= mw);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx_reg    <= ACC_W'(mx[ACC_W-1:32]);
            ry_reg    <= ACC_W'(my[ACC_W-1:32]);
            nx_reg    <= mx[31:0];
            ny_reg    <= my[31:0];
            den_reg   <= mw;
            flags_reg <= flags_next;
        end
    end

    assign r_x   = rx_reg;
    assign r_y   = ry_reg;
    assign num_x = nx_reg;
    assign num_y = ny_reg;
    assign den   = den_reg;
    assign flags = flags_reg;

endmodule
